/* hdl/rcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// Types, constants and helper functions shared by the calendar clock modules.
// ----------------------------------------------------------------------------
package rcc_pkg;

  // configuration register indexes
  localparam logic CFG_BINARY_FORMAT = 1'b0;
  localparam logic CFG_HOUR_24_MODE  = 1'b1;

  // bit m-1 set when month m has 31 days, padded to 16 bits for a 4-bit index
  localparam logic [15:0] LONG_MONTH_MASK = 16'h0AD5;

  localparam logic [13:0] YEAR_MAX       = 14'd9999;
  localparam logic [13:0] YEAR_RESET     = 14'd2000;
  localparam logic [7:0]  CENTURY_ZERO   = 8'd20;
  localparam logic [7:0]  PM_HOUR_OFFSET = 8'd12;
  // 2^19 / 100 rounded up, exact for years up to 9999
  localparam logic [26:0] RECIP_100      = 27'd5243;
  localparam logic [18:0] DIV100_LIMIT   = 19'd4096;

  typedef struct packed {
    logic binary_format;
    logic hour_24_mode;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [13:0] year;
  } cal_t;

  // bcd byte to binary, no digit check; passes through in binary mode
  function automatic logic [7:0] from_raw(input logic [7:0] v, input logic bin);
    logic [7:0] tens;
    tens = {4'd0, v[7:4]} * 8'd10;
    from_raw = bin ? v : (tens + {4'd0, v[3:0]});
  endfunction

  // gregorian leap rule via a reciprocal multiply: the low product bits
  // stay tiny only for multiples of 100, the high bits give the quotient
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic        div100;
    prod   = {13'd0, y} * RECIP_100;
    div100 = prod[18:0] < DIV100_LIMIT;
    is_leap = (y[1:0] == 2'd0) && (!div100 || (prod[20:19] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m < 4'd1 || m > 4'd12) begin
      month_len = 5'd31;
    end else if (m == 4'd2) begin
      month_len = leap ? 5'd29 : 5'd28;
    end else begin
      month_len = 5'd30 + {4'd0, LONG_MONTH_MASK[idx]};
    end
  endfunction

endpackage

/* hdl/rcc_load.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_load
// Converts raw rtc register bytes into a saturated binary calendar.
// ----------------------------------------------------------------------------
module rcc_load import rcc_pkg::*; (
  input  cfg_t       cfg_i,
  input  logic [7:0] raw_second_i,
  input  logic [7:0] raw_minute_i,
  input  logic [7:0] raw_hour_i,
  input  logic [2:0] raw_weekday_i,
  input  logic [7:0] raw_monthday_i,
  input  logic [7:0] raw_month_i,
  input  logic [7:0] raw_year_i,
  input  logic [7:0] raw_century_i,
  output cal_t       cal_o
);

  logic [7:0]  sec_b, min_b, hour_b, mday_b, month_b, year_b, cent_b, cent_adj;
  logic [7:0]  hour_12;
  logic [8:0]  hour_full;
  logic [15:0] year_full;

  always_comb begin
    sec_b   = from_raw(raw_second_i, cfg_i.binary_format);
    min_b   = from_raw(raw_minute_i, cfg_i.binary_format);
    mday_b  = from_raw(raw_monthday_i, cfg_i.binary_format);
    month_b = from_raw(raw_month_i, cfg_i.binary_format);
    year_b  = from_raw(raw_year_i, cfg_i.binary_format);
    cent_b  = from_raw(raw_century_i, cfg_i.binary_format);

    // twelve-hour: strip pm, 12 becomes 0, then add 12 for pm
    if (cfg_i.hour_24_mode) begin
      hour_b    = from_raw(raw_hour_i, cfg_i.binary_format);
      hour_12   = hour_b;
      hour_full = {1'b0, hour_b};
    end else begin
      hour_b    = from_raw({1'b0, raw_hour_i[6:0]}, cfg_i.binary_format);
      hour_12   = (hour_b == PM_HOUR_OFFSET) ? 8'd0 : hour_b;
      hour_full = {1'b0, hour_12} + (raw_hour_i[7] ? {1'b0, PM_HOUR_OFFSET} : 9'd0);
    end

    cent_adj  = (cent_b == 8'd0) ? CENTURY_ZERO : cent_b;
    year_full = ({8'd0, cent_adj} * 16'd100) + {8'd0, year_b};

    cal_o.sec   = (sec_b > 8'd59) ? 6'd59 : sec_b[5:0];
    cal_o.min   = (min_b > 8'd59) ? 6'd59 : min_b[5:0];
    cal_o.hour  = (hour_full > 9'd23) ? 5'd23 : hour_full[4:0];
    cal_o.wday  = (raw_weekday_i == 3'd0) ? 3'd1 : raw_weekday_i;
    cal_o.mday  = (mday_b == 8'd0) ? 5'd1 : ((mday_b > 8'd31) ? 5'd31 : mday_b[4:0]);
    cal_o.month = (month_b == 8'd0) ? 4'd1 : ((month_b > 8'd12) ? 4'd12 : month_b[3:0]);
    cal_o.year  = (year_full > {2'd0, YEAR_MAX}) ? YEAR_MAX : year_full[13:0];
  end

endmodule

/* hdl/rcc_advance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_advance
// Adds one second to a calendar, carrying through to the year.
// ----------------------------------------------------------------------------
module rcc_advance import rcc_pkg::*; (
  input  cal_t cal_i,
  output cal_t cal_o
);

  logic [6:0]  sec_inc, min_inc;
  logic [5:0]  hour_inc, mday_inc;
  logic [3:0]  wday_inc;
  logic [4:0]  month_inc, mlen;
  logic [13:0] year_inc;

  always_comb begin
    sec_inc   = {1'b0, cal_i.sec} + 7'd1;
    min_inc   = {1'b0, cal_i.min} + 7'd1;
    hour_inc  = {1'b0, cal_i.hour} + 6'd1;
    wday_inc  = {1'b0, cal_i.wday} + 4'd1;
    mday_inc  = {1'b0, cal_i.mday} + 6'd1;
    month_inc = {1'b0, cal_i.month} + 5'd1;
    year_inc  = (cal_i.year >= YEAR_MAX) ? 14'd0 : (cal_i.year + 14'd1);
    mlen      = month_len(cal_i.month, is_leap(cal_i.year));

    cal_o = cal_i;
    if (sec_inc < 7'd60) begin
      cal_o.sec = sec_inc[5:0];
    end else begin
      cal_o.sec = 6'd0;
      if (min_inc < 7'd60) begin
        cal_o.min = min_inc[5:0];
      end else begin
        cal_o.min = 6'd0;
        if (hour_inc < 6'd24) begin
          cal_o.hour = hour_inc[4:0];
        end else begin
          cal_o.hour = 5'd0;
          cal_o.wday = (wday_inc > 4'd7) ? 3'd1 : wday_inc[2:0];
          // a day loaded past the month length rolls over on the next carry
          if (mday_inc <= {1'b0, mlen}) begin
            cal_o.mday = mday_inc[4:0];
          end else begin
            cal_o.mday = 5'd1;
            if (month_inc <= 5'd12) begin
              cal_o.month = month_inc[3:0];
            end else begin
              cal_o.month = 4'd1;
              cal_o.year  = year_inc;
            end
          end
        end
      end
    end
  end

endmodule

/* hdl/rtc_calendar_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_counter
// Calendar clock kept from rtc load and interrupt tick transfers.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result side does not stall and
// gives one result per item: the raw bytes are converted into an input
// register, then the calendar state, which doubles as the result register,
// is updated. Throughput is set by the result register alone: a new item
// moves in whenever the result slot is empty or is being taken. A load item
// (cmd 1) converts bcd or binary bytes, 12- or 24-hour, with century zero
// taken as 20 and out-of-range values saturated. A tick item (cmd 0) counts
// the periodic flag into a 10-bit counter and the update flag into a 32-bit
// uptime count, each update also adding one second with gregorian carries.
// Each result is the full state after its item. After reset the calendar
// reads 00:00:00, weekday 1, 1 January 2000, both counters zero, bcd and
// 24-hour modes. Configuration writes are always taken and should only be
// made while no item is in flight.
// ----------------------------------------------------------------------------
module rtc_calendar_counter import rcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic        periodic_flag_i,
  input  logic        update_flag_i,
  input  logic [7:0]  raw_second_i,
  input  logic [7:0]  raw_minute_i,
  input  logic [7:0]  raw_hour_i,
  input  logic [2:0]  raw_weekday_i,
  input  logic [7:0]  raw_monthday_i,
  input  logic [7:0]  raw_month_i,
  input  logic [7:0]  raw_year_i,
  input  logic [7:0]  raw_century_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  sec_now_o,
  output logic [5:0]  min_now_o,
  output logic [4:0]  hour_now_o,
  output logic [2:0]  weekday_now_o,
  output logic [4:0]  day_now_o,
  output logic [3:0]  month_now_o,
  output logic [13:0] year_now_o,
  output logic [9:0]  periodic_count_o,
  output logic [31:0] uptime_seconds_o
);

  // configuration
  cfg_t cfg_q;

  // input register: command, flags and the already converted load values
  logic s1_valid_q;
  logic s1_cmd_q, s1_pf_q, s1_uf_q;
  cal_t s1_load_q;
  cal_t load_cal;

  // calendar state, also the result register
  cal_t        cal_q, cal_d, cal_adv;
  logic [9:0]  tick_q, tick_d;
  logic [31:0] uptime_q, uptime_d;
  logic        out_valid_q;

  logic in_take, s2_ready, s2_take;

  // --------------------------------------------------------------------------
  // configuration writes, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.binary_format <= 1'b0;
      cfg_q.hour_24_mode  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BINARY_FORMAT: cfg_q.binary_format <= cfg_data_i;
        CFG_HOUR_24_MODE:  cfg_q.hour_24_mode  <= cfg_data_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: result slot frees when empty or taken, input register follows
  // --------------------------------------------------------------------------
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s2_take    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // raw byte conversion ahead of the input register
  rcc_load u_load (
    .cfg_i          (cfg_q),
    .raw_second_i   (raw_second_i),
    .raw_minute_i   (raw_minute_i),
    .raw_hour_i     (raw_hour_i),
    .raw_weekday_i  (raw_weekday_i),
    .raw_monthday_i (raw_monthday_i),
    .raw_month_i    (raw_month_i),
    .raw_year_i     (raw_year_i),
    .raw_century_i  (raw_century_i),
    .cal_o          (load_cal)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s2_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q  <= cmd_i;
      s1_pf_q   <= periodic_flag_i;
      s1_uf_q   <= update_flag_i;
      s1_load_q <= load_cal;
    end
  end

  // --------------------------------------------------------------------------
  // state update: load, or tick with counters and one-second carry chain
  // --------------------------------------------------------------------------
  rcc_advance u_advance (
    .cal_i (cal_q),
    .cal_o (cal_adv)
  );

  always_comb begin
    cal_d    = cal_q;
    tick_d   = tick_q;
    uptime_d = uptime_q;
    if (s1_cmd_q) begin
      cal_d = s1_load_q;
    end else begin
      if (s1_pf_q) begin
        tick_d = tick_q + 10'd1;
      end
      if (s1_uf_q) begin
        uptime_d = uptime_q + 32'd1;
        cal_d    = cal_adv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.sec   <= 6'd0;
      cal_q.min   <= 6'd0;
      cal_q.hour  <= 5'd0;
      cal_q.wday  <= 3'd1;
      cal_q.mday  <= 5'd1;
      cal_q.month <= 4'd1;
      cal_q.year  <= YEAR_RESET;
      tick_q      <= 10'd0;
      uptime_q    <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_take) begin
        cal_q    <= cal_d;
        tick_q   <= tick_d;
        uptime_q <= uptime_d;
      end
      if (s2_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sec_now_o        = cal_q.sec;
  assign min_now_o        = cal_q.min;
  assign hour_now_o       = cal_q.hour;
  assign weekday_now_o    = cal_q.wday;
  assign day_now_o        = cal_q.mday;
  assign month_now_o      = cal_q.month;
  assign year_now_o       = cal_q.year;
  assign periodic_count_o = tick_q;
  assign uptime_seconds_o = uptime_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // state only moves on a transfer into the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_take |=> ($stable(cal_q) && $stable(tick_q) && $stable(uptime_q)))
    else $error("calendar state changed without an item");

  // calendar always within range
  a_cal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cal_q.sec <= 6'd59) && (cal_q.min <= 6'd59) && (cal_q.hour <= 5'd23) &&
    (cal_q.wday >= 3'd1) && (cal_q.mday >= 5'd1) && (cal_q.month >= 4'd1) &&
    (cal_q.month <= 4'd12) && (cal_q.year <= YEAR_MAX))
    else $error("calendar field out of range");

  // an update tick counts exactly one event
  a_uptime_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_take && !s1_cmd_q && s1_uf_q) |=> (uptime_q == $past(uptime_q) + 32'd1))
    else $error("uptime count did not advance by one");

  // input held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a stalled result");

endmodule

/* tb/tb_rtc_calendar_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtc_calendar_counter
// Self-checking bench for the rtc calendar clock.
// ----------------------------------------------------------------------------
// Loads and interrupt ticks are sent through the input channel, and each
// accepted transfer runs through a calendar model kept in the bench. The
// model gives the full expected state, which is queued and checked field by
// field against each result transfer. Directed tests cover reset values,
// the tick flags, saturation of loaded bytes, century zero, 12-hour hours,
// binary bytes and the leap-year month rollovers. Then random phases load
// times close to a carry, let update ticks roll them over, and mix in noise
// under every format setting. Both sides pause at random, and one test holds
// the result side off for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb_rtc_calendar_counter;
  import rcc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;   // cycles with no transfer at all
  localparam int unsigned PHASE_ITEMS = 210;
  localparam logic [7:0]  PM_FLAG     = 8'h80;
  // years around the leap rule and the top of the range
  localparam int unsigned PROBE_YEARS [9] = '{1900, 1999, 2000, 2023, 2024, 2096,
                                              2100, 2400, 9999};

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } rtc_cmd_e;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_style_e;

  typedef struct {
    rtc_cmd_e   cmd;
    logic       periodic;
    logic       update;
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [2:0] raw_weekday;
    logic [7:0] raw_monthday;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
  } rtc_event_t;

  typedef struct {
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [13:0] year;
    logic [9:0]  periodic;
    logic [31:0] uptime;
  } calendar_snapshot_t;

  // clock, reset and block ports, all known from time zero
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i      = CFG_BINARY_FORMAT;
  logic        cfg_data_i       = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        cmd_i            = CMD_TICK;
  logic        periodic_flag_i  = 1'b0;
  logic        update_flag_i    = 1'b0;
  logic [7:0]  raw_second_i     = '0;
  logic [7:0]  raw_minute_i     = '0;
  logic [7:0]  raw_hour_i       = '0;
  logic [2:0]  raw_weekday_i    = '0;
  logic [7:0]  raw_monthday_i   = '0;
  logic [7:0]  raw_month_i      = '0;
  logic [7:0]  raw_year_i       = '0;
  logic [7:0]  raw_century_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [5:0]  sec_now_o;
  logic [5:0]  min_now_o;
  logic [4:0]  hour_now_o;
  logic [2:0]  weekday_now_o;
  logic [4:0]  day_now_o;
  logic [3:0]  month_now_o;
  logic [13:0] year_now_o;
  logic [9:0]  periodic_count_o;
  logic [31:0] uptime_seconds_o;

  // calendar model state, same reset values as the block
  cfg_t        fmt            = '{binary_format: 1'b0, hour_24_mode: 1'b1};
  int unsigned cal_sec        = 0;
  int unsigned cal_min        = 0;
  int unsigned cal_hour       = 0;
  int unsigned cal_wday       = 1;
  int unsigned cal_mday       = 1;
  int unsigned cal_month      = 1;
  int unsigned cal_year       = 2000;
  logic [9:0]  periodic_ticks = '0;
  logic [31:0] update_events  = '0;

  calendar_snapshot_t expected_snapshots[$];
  int unsigned        mismatches  = 0;
  int unsigned        quiet_cycles = 0;

  // traffic shaping
  bit           sender_gaps   = 1'b0;
  int           burst_left    = 0;
  stall_style_e stall_style   = STALL_NONE;
  logic [7:0]   stall_pattern = 8'h00;
  int           hold_left     = 0;

  always #5 clk_i = ~clk_i;

  rtc_calendar_counter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .periodic_flag_i  (periodic_flag_i),
    .update_flag_i    (update_flag_i),
    .raw_second_i     (raw_second_i),
    .raw_minute_i     (raw_minute_i),
    .raw_hour_i       (raw_hour_i),
    .raw_weekday_i    (raw_weekday_i),
    .raw_monthday_i   (raw_monthday_i),
    .raw_month_i      (raw_month_i),
    .raw_year_i       (raw_year_i),
    .raw_century_i    (raw_century_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sec_now_o        (sec_now_o),
    .min_now_o        (min_now_o),
    .hour_now_o       (hour_now_o),
    .weekday_now_o    (weekday_now_o),
    .day_now_o        (day_now_o),
    .month_now_o      (month_now_o),
    .year_now_o       (year_now_o),
    .periodic_count_o (periodic_count_o),
    .uptime_seconds_o (uptime_seconds_o)
  );

  // ---------------------------------------------------------------- model --

  // rtc byte to a number under the current format, bcd digits unchecked
  function automatic int unsigned byte_value(input logic [7:0] b);
    if (fmt.binary_format) begin
      return b;
    end
    return b[3:0] + 10 * b[7:4];
  endfunction

  function automatic int unsigned saturate(input int unsigned v, lo, hi);
    if (v < lo) begin
      return lo;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // out-of-range months count as 31 days
  function automatic int unsigned month_days(input int unsigned m, y);
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // one update-ended event: carry through the calendar
  function automatic void roll_one_second();
    cal_sec++;
    if (cal_sec < 60) return;
    cal_sec = 0;
    cal_min++;
    if (cal_min < 60) return;
    cal_min = 0;
    cal_hour++;
    if (cal_hour < 24) return;
    cal_hour = 0;
    cal_wday = (cal_wday >= 7) ? 1 : cal_wday + 1;
    // a loaded day past the month end rolls over here as well
    cal_mday++;
    if (cal_mday <= month_days(cal_month, cal_year)) return;
    cal_mday = 1;
    cal_month++;
    if (cal_month <= 12) return;
    cal_month = 1;
    cal_year = (cal_year >= 9999) ? 0 : cal_year + 1;
  endfunction

  // apply one accepted transfer and return the state that should come out
  function automatic calendar_snapshot_t apply_rtc_event(input rtc_event_t ev);
    calendar_snapshot_t snap;
    int unsigned        h;
    int unsigned        cent;
    if (ev.cmd == CMD_LOAD) begin
      cal_sec = saturate(byte_value(ev.raw_second), 0, 59);
      cal_min = saturate(byte_value(ev.raw_minute), 0, 59);
      if (!fmt.hour_24_mode) begin
        // 12 am is midnight, pm adds twelve after that
        h = byte_value({1'b0, ev.raw_hour[6:0]});
        if (h == 12) h = 0;
        if (ev.raw_hour[7]) h += 12;
      end else begin
        h = byte_value(ev.raw_hour);
      end
      cal_hour  = saturate(h, 0, 23);
      cal_wday  = saturate(ev.raw_weekday, 1, 7);
      cal_mday  = saturate(byte_value(ev.raw_monthday), 1, 31);
      cal_month = saturate(byte_value(ev.raw_month), 1, 12);
      cent = byte_value(ev.raw_century);
      if (cent == 0) cent = 20;
      cal_year = saturate(cent * 100 + byte_value(ev.raw_year), 0, 9999);
    end else begin
      if (ev.periodic) periodic_ticks++;
      if (ev.update) begin
        update_events++;
        roll_one_second();
      end
    end
    snap.sec      = cal_sec[5:0];
    snap.minute   = cal_min[5:0];
    snap.hour     = cal_hour[4:0];
    snap.wday     = cal_wday[2:0];
    snap.mday     = cal_mday[4:0];
    snap.month    = cal_month[3:0];
    snap.year     = cal_year[13:0];
    snap.periodic = periodic_ticks;
    snap.uptime   = update_events;
    return snap;
  endfunction

  // ------------------------------------------------------------- checking --

  task automatic check_field(input string name, input longint unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_snapshot(input calendar_snapshot_t want);
    check_field("sec_now", want.sec, sec_now_o);
    check_field("min_now", want.minute, min_now_o);
    check_field("hour_now", want.hour, hour_now_o);
    check_field("weekday_now", want.wday, weekday_now_o);
    check_field("day_now", want.mday, day_now_o);
    check_field("month_now", want.month, month_now_o);
    check_field("year_now", want.year, year_now_o);
    check_field("periodic_count", want.periodic, periodic_count_o);
    check_field("uptime_seconds", want.uptime, uptime_seconds_o);
  endtask

  // values read right after the edge are the ones the edge sampled, since
  // every driver on both sides updates by nonblocking assignment
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_snapshots.size() == 0) begin
          $error("result transfer with no expected state waiting");
          mismatches++;
        end else begin
          check_snapshot(expected_snapshots.pop_front());
        end
      end
      // watchdog: any transfer on any channel counts as progress
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: a long hold-off when asked, else the stall style of the phase
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_style)
        STALL_NONE: begin
          out_stall_i <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall_i <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          out_stall_i <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  // ------------------------------------------------------------- drivers --

  // one input transfer; valid stays high after it unless a gap follows
  task automatic send_event(input rtc_event_t ev);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= ev.cmd;
    periodic_flag_i <= ev.periodic;
    update_flag_i   <= ev.update;
    raw_second_i    <= ev.raw_second;
    raw_minute_i    <= ev.raw_minute;
    raw_hour_i      <= ev.raw_hour;
    raw_weekday_i   <= ev.raw_weekday;
    raw_monthday_i  <= ev.raw_monthday;
    raw_month_i     <= ev.raw_month;
    raw_year_i      <= ev.raw_year;
    raw_century_i   <= ev.raw_century;
    do @(posedge clk_i); while (in_stall_o);
    expected_snapshots.push_back(apply_rtc_event(ev));
    if (burst_left > 0) burst_left--;
  endtask

  // every field random, whatever the command
  function automatic rtc_event_t random_event();
    rtc_event_t ev;
    ev.cmd          = rtc_cmd_e'($urandom_range(0, 1));
    ev.periodic     = 1'($urandom_range(0, 1));
    ev.update       = 1'($urandom_range(0, 1));
    ev.raw_second   = 8'($urandom);
    ev.raw_minute   = 8'($urandom);
    ev.raw_hour     = 8'($urandom);
    ev.raw_weekday  = 3'($urandom);
    ev.raw_monthday = 8'($urandom);
    ev.raw_month    = 8'($urandom);
    ev.raw_year     = 8'($urandom);
    ev.raw_century  = 8'($urandom);
    return ev;
  endfunction

  // tick with random raw bytes, which the block must ignore
  task automatic send_tick(input logic periodic, update);
    rtc_event_t ev;
    ev          = random_event();
    ev.cmd      = CMD_TICK;
    ev.periodic = periodic;
    ev.update   = update;
    send_event(ev);
  endtask

  task automatic send_raw_load(input logic [7:0] s, mi, h, input logic [2:0] wd,
                               input logic [7:0] d, mo, yr, ce);
    rtc_event_t ev;
    ev              = random_event();
    ev.cmd          = CMD_LOAD;
    ev.raw_second   = s;
    ev.raw_minute   = mi;
    ev.raw_hour     = h;
    ev.raw_weekday  = wd;
    ev.raw_monthday = d;
    ev.raw_month    = mo;
    ev.raw_year     = yr;
    ev.raw_century  = ce;
    send_event(ev);
  endtask

  // number below 100 to an rtc byte under the current format
  function automatic logic [7:0] to_raw(input int unsigned v);
    return fmt.binary_format ? 8'(v) : 8'((v / 10) * 16 + v % 10);
  endfunction

  function automatic logic [7:0] hour_to_raw(input int unsigned h);
    if (fmt.hour_24_mode) return to_raw(h);
    if (h == 0) return to_raw(12);
    if (h < 12) return to_raw(h);
    return PM_FLAG | to_raw((h == 12) ? 12 : h - 12);
  endfunction

  // load a calendar time written in plain numbers
  task automatic load_calendar(input int unsigned s, mi, h, wd, d, mo, y);
    send_raw_load(to_raw(s), to_raw(mi), hour_to_raw(h), 3'(wd), to_raw(d),
                  to_raw(mo), to_raw(y % 100), to_raw(y / 100));
  endtask

  // lower valid and let every expected result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_snapshots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_BINARY_FORMAT: begin
        fmt.binary_format = value;
      end
      default: begin
        fmt.hour_24_mode = value;
      end
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // only while idle
  task automatic set_format(input logic binary, input logic h24);
    drain_results();
    write_reg(CFG_BINARY_FORMAT, binary);
    write_reg(CFG_HOUR_24_MODE, h24);
  endtask

  // ---------------------------------------------------------------- tests --

  // reset state comes out on a flagless tick, then each flag and both
  task automatic check_reset_and_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
  endtask

  // all-zero bytes: century zero and day, month and weekday forced to one;
  // all-ones bytes saturate, and the next second wraps year 9999 to 0
  task automatic check_load_saturation();
    set_format(1'b0, 1'b1);
    send_raw_load(8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_raw_load(8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick(1'b0, 1'b1);
  endtask

  // last second of a day rolled over on month ends around the leap rule
  task automatic check_month_rollover();
    load_calendar(59, 59, 23, 2, 29, 2, 2000);
    send_tick(1'b0, 1'b1);
    load_calendar(59, 59, 23, 3, 28, 2, 1900);
    send_tick(1'b0, 1'b1);
    load_calendar(59, 59, 23, 4, 28, 2, 2024);
    send_tick(1'b1, 1'b1);
    // day past the month end, then an April month end
    load_calendar(59, 59, 23, 5, 31, 2, 2023);
    send_tick(1'b0, 1'b1);
    load_calendar(59, 59, 23, 6, 30, 4, 2023);
    send_tick(1'b0, 1'b1);
  endtask

  // 12 am, 12 pm, 1 pm and an hour byte that saturates
  task automatic check_twelve_hour();
    set_format(1'b0, 1'b0);
    send_raw_load(8'h30, 8'h15, 8'h12, 3'd1, 8'h15, 8'h06, 8'h50, 8'h19);
    send_raw_load(8'h30, 8'h15, 8'h92, 3'd2, 8'h15, 8'h06, 8'h50, 8'h19);
    send_raw_load(8'h30, 8'h15, 8'h81, 3'd3, 8'h15, 8'h06, 8'h50, 8'h19);
    send_raw_load(8'h30, 8'h15, 8'hFF, 3'd4, 8'h15, 8'h06, 8'h50, 8'h19);
  endtask

  task automatic check_binary_bytes();
    set_format(1'b1, 1'b0);
    send_raw_load(8'd0, 8'd0, 8'h8C, 3'd5, 8'd1, 8'd1, 8'd0, 8'd0);
    set_format(1'b1, 1'b1);
    send_raw_load(8'd59, 8'd59, 8'd23, 3'd7, 8'd31, 8'd12, 8'd99, 8'd99);
    send_raw_load(8'hFF, 8'hFF, 8'hFF, 3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // result side held off long enough that the block stalls its input
  task automatic check_backpressure();
    set_format(1'b0, 1'b1);
    sender_gaps = 1'b0;
    stall_style = STALL_NONE;
    hold_left   = 60;
    repeat (30) begin
      if ($urandom_range(0, 3) == 0) begin
        send_event(random_event());
      end else begin
        send_tick(1'b1, 1'b1);
      end
    end
  endtask

  // a time a few seconds before some carry, often the last day of the month
  task automatic load_near_carry();
    int unsigned y;
    int unsigned mo;
    int unsigned d;
    y  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9999)
                                     : PROBE_YEARS[$urandom_range(0, 8)];
    mo = ($urandom_range(0, 1) == 0) ? 12 : $urandom_range(1, 12);
    d  = ($urandom_range(0, 4) < 3) ? month_days(mo, y) : $urandom_range(1, 31);
    load_calendar($urandom_range(50, 59),
                  ($urandom_range(0, 4) < 3) ? 59 : $urandom_range(0, 59),
                  ($urandom_range(0, 4) < 3) ? 23 : $urandom_range(0, 23),
                  $urandom_range(1, 7), d, mo, y);
  endtask

  task automatic run_random_phase(input logic binary, h24, input bit gaps,
                                  input stall_style_e style);
    int sent;
    set_format(binary, h24);
    sender_gaps   = gaps;
    stall_style   = style;
    stall_pattern = 8'($urandom) & 8'h7F;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        // a load close to a carry, then mostly update ticks across it
        load_near_carry();
        sent++;
        repeat ($urandom_range(4, 20)) begin
          send_tick($urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_event(random_event());
          sent++;
        end
      end
    end
  endtask

  task automatic check_random_calendar();
    run_random_phase(1'b0, 1'b1, 1'b1, STALL_RANDOM);
    run_random_phase(1'b0, 1'b0, 1'b0, STALL_NONE);
    run_random_phase(1'b1, 1'b1, 1'b1, STALL_PATTERN);
    run_random_phase(1'b1, 1'b0, 1'b1, STALL_RANDOM);
    run_random_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                     STALL_PATTERN);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reset_and_ticks();
    check_load_saturation();
    check_month_rollover();
    check_twelve_hour();
    check_binary_bytes();
    check_backpressure();
    check_random_calendar();
    // the watchdog ends the run if results stop coming
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
